// ----- design/cmbus_pkg.sv -----
package cmbus_pkg;

    // bus access codes
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_DMA   = 2'd2;

    // request transaction
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] bus_addr;
        logic [7:0]  write_data;
    } t_in_item;

    // response transaction
    typedef struct packed {
        logic [7:0] read_data;
        logic       accepted;
    } t_out_item;

    // controller to datapath
    typedef struct packed {
        logic clearing;
        logic take;
        logic capture;
        logic dma_run;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_read;
        logic start_dma;
        logic clear_done;
        logic dma_done;
    } t_dp_status;

endpackage

// ----- design/cmbus_ram.sv -----
module cmbus_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/cmbus_ctrl.sv -----
module cmbus_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output cmbus_pkg::t_dp_cmd    o_cmd,
    input  cmbus_pkg::t_dp_status i_status
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_DMA
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   take;

    // output register is free when empty or drained this cycle
    assign out_free   = !r_out_valid || !i_out_stall;
    assign take       = (r_state == S_IDLE) && out_free && i_in_valid;
    assign o_in_stall = !((r_state == S_IDLE) && out_free);
    assign o_out_valid = r_out_valid;

    // commands to the datapath
    assign o_cmd.clearing = (r_state == S_CLEAR);
    assign o_cmd.take     = take;
    assign o_cmd.capture  = (r_state == S_READ);
    assign o_cmd.dma_run  = (r_state == S_DMA);

    // next state
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (take) begin
                    if (i_status.need_read) begin
                        n_state = S_READ;
                    end else begin
                        n_out_valid = 1'b1;
                        if (i_status.start_dma) begin
                            n_state = S_DMA;
                        end
                    end
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            S_DMA: begin
                if (i_status.dma_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and response valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // a read waits for ram data with the response register empty
    a_read_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !r_out_valid)
        else $error("response register busy while read data returns");

    // read data lands in the response register in the cycle after the read state
    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> (r_state == S_IDLE) && o_out_valid)
        else $error("read response not presented after ram latency");

endmodule

// ----- design/cmbus_dp.sv -----
module cmbus_dp #(
    parameter int VIDEO_RAM_BYTES    = 8192,
    parameter int WORK_RAM_BYTES     = 8192,
    parameter int SPRITE_TABLE_BYTES = 160
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cmbus_pkg::t_dp_cmd    i_cmd,
    output cmbus_pkg::t_dp_status o_status,
    input  cmbus_pkg::t_in_item   i_in_data,
    output cmbus_pkg::t_out_item  o_out_data
);

    localparam int VAW        = $clog2(VIDEO_RAM_BYTES);
    localparam int WAW        = $clog2(WORK_RAM_BYTES);
    localparam int SAW        = $clog2(SPRITE_TABLE_BYTES);
    localparam int SCW        = $clog2(SPRITE_TABLE_BYTES + 1);
    localparam int IO_DEPTH   = 128;
    localparam int HIGH_DEPTH = 127;
    localparam int IAW        = $clog2(IO_DEPTH);
    localparam int HAW        = $clog2(HIGH_DEPTH);
    localparam int CLR_A      = (VIDEO_RAM_BYTES > WORK_RAM_BYTES) ? VIDEO_RAM_BYTES
                                                                   : WORK_RAM_BYTES;
    localparam int CLR_B      = (CLR_A > SPRITE_TABLE_BYTES) ? CLR_A : SPRITE_TABLE_BYTES;
    localparam int CLR_DEPTH  = (CLR_B > IO_DEPTH) ? CLR_B : IO_DEPTH;
    localparam int CW         = $clog2(CLR_DEPTH);

    localparam int VIDEO_BASE  = 32'h8000;
    localparam int WORK_BASE   = 32'hC000;
    localparam int SPRITE_BASE = 32'hFE00;
    localparam int IO_BASE     = 32'hFF00;
    localparam int HIGH_BASE   = 32'hFF80;
    localparam int IE_ADDR     = 32'hFFFF;
    localparam logic [IAW-1:0] MODE_OFF = 7'h41;
    localparam logic [IAW-1:0] DMA_OFF  = 7'h46;
    localparam logic [7:0]     MODE_2   = 8'd2;
    localparam logic [7:0]     MODE_3   = 8'd3;

    typedef enum logic [2:0] {
        RG_NONE,
        RG_VIDEO,
        RG_WORK,
        RG_SPRITE,
        RG_IO,
        RG_HIGH,
        RG_IE
    } t_region;

    // mapped bytes of the i/o page
    function automatic logic io_mapped(input logic [IAW-1:0] off);
        logic hit;
        case (off) inside
            7'h00, 7'h0F, 7'h4F, 7'h70,
            [7'h01:7'h02], [7'h04:7'h07], [7'h10:7'h26], [7'h30:7'h3F],
            [7'h40:7'h4D], [7'h50:7'h56], [7'h68:7'h6C]: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

    logic [7:0]     r_mode;
    logic [7:0]     r_dma_page;
    logic [7:0]     r_ie;
    logic [CW-1:0]  r_clr_cnt;
    logic [SCW-1:0] r_dma_cnt;
    logic           r_dma_wv;
    logic [SAW-1:0] r_dma_wi;
    t_region        r_rd_region;
    logic           r_rd_ok;
    cmbus_pkg::t_out_item r_out;

    logic [31:0]    addr32;
    logic [31:0]    src32;
    logic [15:0]    video_off;
    logic [15:0]    work_off;
    logic [15:0]    sprite_off;
    logic [15:0]    high_off;
    logic [15:0]    dma_src;
    t_region        region;
    logic           hit_ok;
    logic           page_ok;
    logic           bus_wr;
    logic           dma_issue;
    logic           clear_done;
    logic [31:0]    clr32;

    logic           v_we, w_we, s_we, i_we, h_we;
    logic [VAW-1:0] v_waddr, v_raddr;
    logic [WAW-1:0] w_waddr, w_raddr;
    logic [SAW-1:0] s_waddr, s_raddr;
    logic [IAW-1:0] i_waddr, i_raddr;
    logic [HAW-1:0] h_waddr, h_raddr;
    logic [7:0]     v_wdata, w_wdata, s_wdata, i_wdata, h_wdata;
    logic [7:0]     v_rdata, w_rdata, s_rdata, i_rdata, h_rdata;
    logic [7:0]     rd_sel;

    // address decode and display-mode blocking
    assign addr32     = {16'd0, i_in_data.bus_addr};
    assign video_off  = i_in_data.bus_addr - 16'(VIDEO_BASE);
    assign work_off   = i_in_data.bus_addr - 16'(WORK_BASE);
    assign sprite_off = i_in_data.bus_addr - 16'(SPRITE_BASE);
    assign high_off   = i_in_data.bus_addr - 16'(HIGH_BASE);

    always_comb begin
        region = RG_NONE;
        hit_ok = 1'b0;
        if (addr32 >= VIDEO_BASE && addr32 < VIDEO_BASE + VIDEO_RAM_BYTES) begin
            region = RG_VIDEO;
            hit_ok = (r_mode != MODE_3);
        end else if (addr32 >= WORK_BASE && addr32 < WORK_BASE + WORK_RAM_BYTES) begin
            region = RG_WORK;
            hit_ok = 1'b1;
        end else if (addr32 >= SPRITE_BASE &&
                     addr32 < SPRITE_BASE + SPRITE_TABLE_BYTES) begin
            region = RG_SPRITE;
            hit_ok = (r_mode != MODE_2) && (r_mode != MODE_3);
        end else if (addr32 >= IO_BASE && addr32 < HIGH_BASE) begin
            region = RG_IO;
            hit_ok = io_mapped(i_in_data.bus_addr[IAW-1:0]);
        end else if (addr32 >= HIGH_BASE && addr32 < IE_ADDR) begin
            region = RG_HIGH;
            hit_ok = 1'b1;
        end else if (addr32 == IE_ADDR) begin
            region = RG_IE;
            hit_ok = 1'b1;
        end
    end

    // dma source page and copy addressing
    assign src32     = {16'd0, r_dma_page, 8'h00};
    assign page_ok   = (src32 >= WORK_BASE) && (src32 < WORK_BASE + WORK_RAM_BYTES);
    assign dma_src   = {r_dma_page, 8'h00} - 16'(WORK_BASE) + 16'(r_dma_cnt);
    assign dma_issue = i_cmd.dma_run && (r_dma_cnt < SCW'(SPRITE_TABLE_BYTES));

    assign bus_wr     = i_cmd.take && (i_in_data.action == cmbus_pkg::ACT_WRITE) && hit_ok;
    assign clr32      = 32'(r_clr_cnt);
    assign clear_done = (r_clr_cnt == CW'(CLR_DEPTH - 1));

    // status to the controller
    assign o_status.need_read  = (i_in_data.action == cmbus_pkg::ACT_READ);
    assign o_status.start_dma  = (i_in_data.action == cmbus_pkg::ACT_DMA) && page_ok;
    assign o_status.clear_done = clear_done;
    assign o_status.dma_done   = r_dma_wv && (r_dma_wi == SAW'(SPRITE_TABLE_BYTES - 1));

    // write ports: clearing pass, dma copy, bus write
    always_comb begin
        v_we    = (i_cmd.clearing && clr32 < VIDEO_RAM_BYTES) ||
                  (bus_wr && region == RG_VIDEO);
        v_waddr = i_cmd.clearing ? r_clr_cnt[VAW-1:0] : video_off[VAW-1:0];
        v_wdata = i_cmd.clearing ? 8'h00 : i_in_data.write_data;

        w_we    = (i_cmd.clearing && clr32 < WORK_RAM_BYTES) ||
                  (bus_wr && region == RG_WORK);
        w_waddr = i_cmd.clearing ? r_clr_cnt[WAW-1:0] : work_off[WAW-1:0];
        w_wdata = i_cmd.clearing ? 8'h00 : i_in_data.write_data;

        s_we    = (i_cmd.clearing && clr32 < SPRITE_TABLE_BYTES) || r_dma_wv ||
                  (bus_wr && region == RG_SPRITE);
        if (i_cmd.clearing) begin
            s_waddr = r_clr_cnt[SAW-1:0];
            s_wdata = 8'h00;
        end else if (r_dma_wv) begin
            s_waddr = r_dma_wi;
            s_wdata = w_rdata;
        end else begin
            s_waddr = sprite_off[SAW-1:0];
            s_wdata = i_in_data.write_data;
        end

        i_we    = (i_cmd.clearing && clr32 < IO_DEPTH) || (bus_wr && region == RG_IO);
        i_waddr = i_cmd.clearing ? r_clr_cnt[IAW-1:0] : i_in_data.bus_addr[IAW-1:0];
        i_wdata = i_cmd.clearing ? 8'h00 : i_in_data.write_data;

        h_we    = (i_cmd.clearing && clr32 < HIGH_DEPTH) || (bus_wr && region == RG_HIGH);
        h_waddr = i_cmd.clearing ? r_clr_cnt[HAW-1:0] : high_off[HAW-1:0];
        h_wdata = i_cmd.clearing ? 8'h00 : i_in_data.write_data;
    end

    // read ports
    assign v_raddr = video_off[VAW-1:0];
    assign w_raddr = i_cmd.dma_run ? dma_src[WAW-1:0] : work_off[WAW-1:0];
    assign s_raddr = sprite_off[SAW-1:0];
    assign i_raddr = i_in_data.bus_addr[IAW-1:0];
    assign h_raddr = high_off[HAW-1:0];

    cmbus_ram #(.WIDTH(8), .DEPTH(VIDEO_RAM_BYTES)) u_video_ram (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );

    cmbus_ram #(.WIDTH(8), .DEPTH(WORK_RAM_BYTES)) u_work_ram (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    cmbus_ram #(.WIDTH(8), .DEPTH(SPRITE_TABLE_BYTES)) u_sprite_ram (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata)
    );

    cmbus_ram #(.WIDTH(8), .DEPTH(IO_DEPTH)) u_io_ram (
        .i_clk(i_clk), .i_we(i_we), .i_waddr(i_waddr), .i_wdata(i_wdata),
        .i_raddr(i_raddr), .o_rdata(i_rdata)
    );

    cmbus_ram #(.WIDTH(8), .DEPTH(HIGH_DEPTH)) u_high_ram (
        .i_clk(i_clk), .i_we(h_we), .i_waddr(h_waddr), .i_wdata(h_wdata),
        .i_raddr(h_raddr), .o_rdata(h_rdata)
    );

    // read data select for the pending read
    always_comb begin
        case (r_rd_region)
            RG_VIDEO:  rd_sel = v_rdata;
            RG_WORK:   rd_sel = w_rdata;
            RG_SPRITE: rd_sel = s_rdata;
            RG_IO:     rd_sel = i_rdata;
            RG_HIGH:   rd_sel = h_rdata;
            RG_IE:     rd_sel = r_ie;
            default:   rd_sel = 8'hFF;
        endcase
    end

    // mode, dma page and interrupt-enable shadows, clear and dma counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 8'h00;
            r_dma_page <= 8'h00;
            r_ie       <= 8'h00;
            r_clr_cnt  <= '0;
            r_dma_cnt  <= '0;
            r_dma_wv   <= 1'b0;
        end else begin
            if (bus_wr && region == RG_IO && i_in_data.bus_addr[IAW-1:0] == MODE_OFF) begin
                r_mode <= i_in_data.write_data;
            end
            if (bus_wr && region == RG_IO && i_in_data.bus_addr[IAW-1:0] == DMA_OFF) begin
                r_dma_page <= i_in_data.write_data;
            end
            if (bus_wr && region == RG_IE) begin
                r_ie <= i_in_data.write_data;
            end
            if (i_cmd.clearing) begin
                r_clr_cnt <= r_clr_cnt + CW'(1);
            end
            if (i_cmd.take) begin
                r_dma_cnt <= '0;
            end else if (dma_issue) begin
                r_dma_cnt <= r_dma_cnt + SCW'(1);
            end
            r_dma_wv <= dma_issue;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_dma_wi <= r_dma_cnt[SAW-1:0];
        if (i_cmd.take) begin
            r_rd_region <= region;
            r_rd_ok     <= hit_ok;
            r_out.read_data <= 8'h00;
            case (i_in_data.action)
                cmbus_pkg::ACT_WRITE: r_out.accepted <= hit_ok;
                cmbus_pkg::ACT_DMA:   r_out.accepted <= page_ok;
                default:              r_out.accepted <= 1'b0;
            endcase
        end else if (i_cmd.capture) begin
            r_out.read_data <= r_rd_ok ? rd_sel : 8'hFF;
            r_out.accepted  <= r_rd_ok;
        end
    end

    assign o_out_data = r_out;

    // copy writes only happen while the controller runs the dma
    a_dma_write_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dma_wv |-> i_cmd.dma_run && !bus_wr)
        else $error("sprite copy write outside dma");

    // copy counter never passes the table size
    a_dma_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dma_cnt <= SCW'(SPRITE_TABLE_BYTES))
        else $error("dma counter overran sprite table");

endmodule

// ----- design/console_memory_bus_with_oam_dma_unit.sv -----
// channel    direction  handshake                 payload
// request    in         i_in_valid / o_in_stall   i_in_data  (action, bus_addr, write_data)
// response   out        o_out_valid / i_out_stall o_out_data (read_data, accepted)
//
// after reset a clearing pass zeroes all stores, with no request taken until it is done
// write, dma start and unused codes: response registered at the accepting edge
// read: data passes the registered ram read port, then is loaded into the response register
// dma: the block stays busy after the start until the sprite copy is done, one work ram read per cycle
// a new request is taken once the block is idle and the response register is empty or being drained
module console_memory_bus_with_oam_dma_unit #(
    parameter int VIDEO_RAM_BYTES    = 8192,
    parameter int WORK_RAM_BYTES     = 8192,
    parameter int SPRITE_TABLE_BYTES = 160
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cmbus_pkg::t_in_item  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cmbus_pkg::t_out_item o_out_data
);

    cmbus_pkg::t_dp_cmd    cmd;
    cmbus_pkg::t_dp_status status;

    // sequencing of clear, read, write and dma
    cmbus_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_status    (status)
    );

    // decode, stores and response register
    cmbus_dp #(
        .VIDEO_RAM_BYTES    (VIDEO_RAM_BYTES),
        .WORK_RAM_BYTES     (WORK_RAM_BYTES),
        .SPRITE_TABLE_BYTES (SPRITE_TABLE_BYTES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_data  (i_in_data),
        .o_out_data (o_out_data)
    );

endmodule
